/* rtl/core/gdd_pkg.sv */
package gdd_pkg;

    // Default year width; the year wraps modulo 2**YEAR_BITS.
    localparam int YEAR_BITS_DEF = 16;

    // Field widths fixed by the interface.
    localparam int CMD_W   = 3;
    localparam int COUNT_W = 15;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;

    // Day-step counter holds up to step_count * 7.
    localparam int STEPS_W = COUNT_W + 3;

    // Year multiplier is at most 1000, so 10 bits.
    localparam int MULT_W = 10;
    localparam int PROD_W = COUNT_W + MULT_W;

    // Residue of the year modulo 25 (needed for the century rules).
    localparam int RES_W = 5;
    localparam logic [RES_W-1:0] RES_MOD = 5'd25;

    // Unit command codes. The last code selects no unit.
    typedef enum logic [CMD_W-1:0] {
        CMD_DAYS      = 3'd0,
        CMD_WEEKS     = 3'd1,
        CMD_MONTHS    = 3'd2,
        CMD_YEARS     = 3'd3,
        CMD_DECADES   = 3'd4,
        CMD_CENTURIES = 3'd5,
        CMD_MILLENNIA = 3'd6,
        CMD_UNUSED    = 3'd7
    } t_cmd;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_LOOP,
        S_SUB,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mod_step;
        logic date_step;
        logic year_sub;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mod_last;
        logic steps_zero;
    } t_dp_status;

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Number of days in a month (1..12), given whether the year is a leap year.
    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        len = 5'd31;
        if (month == 4'd2) begin
            len = leap ? 5'd29 : 5'd28;
        end else if (month >= 4'd1 && month <= 4'd12) begin
            len = MONTH_LEN[month - 4'd1];
        end
        return len;
    endfunction

    // Residue of 2**n modulo 25, evaluated at elaboration.
    function automatic int pow2_mod25(input int n);
        int v;
        v = 1;
        for (int i = 0; i < n; i++) begin
            v = v * 2;
            if (v >= 25) begin
                v = v - 25;
            end
        end
        return v;
    endfunction

endpackage

/* rtl/core/gregorian_date_decrement.sv */
// A year, decade, century or millennium command runs from the start transfer through the year
// subtraction to the done strobe, an unused command goes straight to done, and a day, week or
// month command forms the year residue, then steps back N times (N up to 229369) before done.
// The day and month loop does one step per cycle; the year residue unit registers two folds.
// A new start transfer is taken in the cycle that shows the result; the receiver cannot stall.
// Reset is synchronous and active low; it returns the controller to idle, no result pending.
module gregorian_date_decrement #(
    parameter int YEAR_BITS = gdd_pkg::YEAR_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [gdd_pkg::CMD_W-1:0]        i_command,
    input  logic [gdd_pkg::COUNT_W-1:0]      i_step_count,
    input  logic [gdd_pkg::DAY_W-1:0]        i_start_day,
    input  logic [gdd_pkg::MONTH_W-1:0]      i_start_month,
    input  logic signed [YEAR_BITS-1:0]      i_start_year,
    output logic                             o_done,
    output logic [gdd_pkg::DAY_W-1:0]        o_result_day,
    output logic [gdd_pkg::MONTH_W-1:0]      o_result_month,
    output logic signed [YEAR_BITS-1:0]      o_result_year
);

    gdd_pkg::t_dp_cmd    dp_cmd;
    gdd_pkg::t_dp_status dp_status;

    // Sequencing of load, residue, stepping and year subtraction.
    gdd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_status  (dp_status),
        .o_cmd     (dp_cmd),
        .o_busy    (busy),
        .o_done    (o_done)
    );

    // Date registers and step arithmetic.
    gdd_datapath #(
        .YEAR_BITS (YEAR_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_cmd          (dp_cmd),
        .i_command      (i_command),
        .i_step_count   (i_step_count),
        .i_start_day    (i_start_day),
        .i_start_month  (i_start_month),
        .i_start_year   (i_start_year),
        .o_status       (dp_status),
        .o_result_day   (o_result_day),
        .o_result_month (o_result_month),
        .o_result_year  (o_result_year)
    );

`ifndef SYNTH
    // A result strobe leaves the block ready for the next transfer.
    a_done_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("done strobe while busy");

    // Year-type commands finish in a fixed number of cycles.
    a_year_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == gdd_pkg::CMD_YEARS ||
         i_command == gdd_pkg::CMD_DECADES || i_command == gdd_pkg::CMD_CENTURIES ||
         i_command == gdd_pkg::CMD_MILLENNIA)) |-> ##2 o_done)
        else $error("year command did not finish in time");

    // A transfer with the unused code completes in the next cycle.
    a_unused_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command == gdd_pkg::CMD_UNUSED) |=> o_done)
        else $error("unused command did not pass through");

    // Results always carry a valid month and a nonzero day.
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result_month >= 4'd1 && o_result_month <= 4'd12 &&
                    o_result_day != 5'd0))
        else $error("result date out of range");
`endif

endmodule

/* rtl/core/gdd_ctrl.sv */
module gdd_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [gdd_pkg::CMD_W-1:0]  i_command,
    input  gdd_pkg::t_dp_status        i_status,
    output gdd_pkg::t_dp_cmd           o_cmd,
    output logic                       o_busy,
    output logic                       o_done
);

    gdd_pkg::t_state r_state;
    gdd_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gdd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            gdd_pkg::S_IDLE, gdd_pkg::S_DONE: begin
                if (i_start) begin
                    case (gdd_pkg::t_cmd'(i_command))
                        gdd_pkg::CMD_DAYS,
                        gdd_pkg::CMD_WEEKS,
                        gdd_pkg::CMD_MONTHS:    n_state = gdd_pkg::S_MOD;
                        gdd_pkg::CMD_YEARS,
                        gdd_pkg::CMD_DECADES,
                        gdd_pkg::CMD_CENTURIES,
                        gdd_pkg::CMD_MILLENNIA: n_state = gdd_pkg::S_SUB;
                        default:                n_state = gdd_pkg::S_DONE;
                    endcase
                end else begin
                    n_state = gdd_pkg::S_IDLE;
                end
            end
            gdd_pkg::S_MOD: begin
                if (i_status.mod_last) begin
                    n_state = gdd_pkg::S_LOOP;
                end
            end
            gdd_pkg::S_LOOP: begin
                if (i_status.steps_zero) begin
                    n_state = gdd_pkg::S_DONE;
                end
            end
            gdd_pkg::S_SUB: n_state = gdd_pkg::S_DONE;
            default:        n_state = gdd_pkg::S_IDLE;
        endcase
    end

    // Outputs. The done cycle also takes a new transfer, since the result
    // is sampled at the same edge that loads the next item.
    always_comb begin
        o_busy          = 1'b1;
        o_done          = 1'b0;
        o_cmd.load      = 1'b0;
        o_cmd.mod_step  = 1'b0;
        o_cmd.date_step = 1'b0;
        o_cmd.year_sub  = 1'b0;
        case (r_state)
            gdd_pkg::S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            gdd_pkg::S_DONE: begin
                o_busy     = 1'b0;
                o_done     = 1'b1;
                o_cmd.load = i_start;
            end
            gdd_pkg::S_MOD:  o_cmd.mod_step  = 1'b1;
            gdd_pkg::S_LOOP: o_cmd.date_step = !i_status.steps_zero;
            gdd_pkg::S_SUB:  o_cmd.year_sub  = 1'b1;
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

/* rtl/core/gdd_datapath.sv */
module gdd_datapath #(
    parameter int YEAR_BITS = gdd_pkg::YEAR_BITS_DEF
) (
    input  logic                             i_clk,
    input  gdd_pkg::t_dp_cmd                 i_cmd,
    input  logic [gdd_pkg::CMD_W-1:0]        i_command,
    input  logic [gdd_pkg::COUNT_W-1:0]      i_step_count,
    input  logic [gdd_pkg::DAY_W-1:0]        i_start_day,
    input  logic [gdd_pkg::MONTH_W-1:0]      i_start_month,
    input  logic signed [YEAR_BITS-1:0]      i_start_year,
    output gdd_pkg::t_dp_status              o_status,
    output logic [gdd_pkg::DAY_W-1:0]        o_result_day,
    output logic [gdd_pkg::MONTH_W-1:0]      o_result_month,
    output logic signed [YEAR_BITS-1:0]      o_result_year
);

    localparam int WIDE_W = (gdd_pkg::PROD_W > YEAR_BITS) ? gdd_pkg::PROD_W : YEAR_BITS;
    localparam int RES_W  = gdd_pkg::RES_W;
    localparam int FOLD_W = 12;
    localparam logic [RES_W-1:0] POW_RES = RES_W'(gdd_pkg::pow2_mod25(YEAR_BITS));
    localparam logic [RES_W-1:0] NEG_RES = gdd_pkg::RES_MOD - POW_RES;
    localparam logic [YEAR_BITS-1:0] YEAR_ONE = {{(YEAR_BITS-1){1'b0}}, 1'b1};
    localparam logic [YEAR_BITS-1:0] YEAR_MIN = {1'b1, {(YEAR_BITS-1){1'b0}}};

    logic [gdd_pkg::DAY_W-1:0]   r_day;
    logic [gdd_pkg::MONTH_W-1:0] r_month;
    logic [YEAR_BITS-1:0]        r_year;
    logic [gdd_pkg::STEPS_W-1:0] r_steps;
    logic [WIDE_W-1:0]           r_prod;
    logic [FOLD_W-1:0]           r_fold;
    logic                        r_mod_phase;
    logic [RES_W-1:0]            r_res;
    logic                        r_month_mode;

    logic [gdd_pkg::DAY_W-1:0]   fix_day;
    logic [gdd_pkg::MONTH_W-1:0] fix_month;
    logic [gdd_pkg::STEPS_W-1:0] load_steps;
    logic [gdd_pkg::MULT_W-1:0]  mult;
    logic [gdd_pkg::PROD_W-1:0]  prod_full;
    logic [WIDE_W-1:0]           n_prod;
    logic [31:0]                 year_ext;
    logic [FOLD_W-1:0]           fold_sum;
    logic [10:0]                 fold_hi;
    logic [7:0]                  fold_mid;
    logic [6:0]                  fold_lo;
    logic [RES_W-1:0]            res_fold;
    logic                        leap;
    logic [gdd_pkg::DAY_W-1:0]   n_day;
    logic [gdd_pkg::MONTH_W-1:0] n_month;
    logic                        year_dec;
    logic [RES_W:0]              wrap_sum;
    logic [RES_W-1:0]            res_dec;
    logic [gdd_pkg::MONTH_W-1:0] prev_month;
    logic [gdd_pkg::DAY_W-1:0]   lim;

    // Input fix-ups: day zero reads as 1, months clamp into 1..12.
    always_comb begin
        fix_day   = (i_start_day == '0) ? 5'd1 : i_start_day;
        fix_month = i_start_month;
        if (i_start_month == '0) begin
            fix_month = 4'd1;
        end else if (i_start_month > 4'd12) begin
            fix_month = 4'd12;
        end
    end

    // Step count and year multiplier selected by the command.
    always_comb begin
        load_steps = {3'b000, i_step_count};
        mult       = 10'd1;
        case (gdd_pkg::t_cmd'(i_command))
            gdd_pkg::CMD_WEEKS:     load_steps = {i_step_count, 3'b000} - {3'b000, i_step_count};
            gdd_pkg::CMD_DECADES:   mult = 10'd10;
            gdd_pkg::CMD_CENTURIES: mult = 10'd100;
            gdd_pkg::CMD_MILLENNIA: mult = 10'd1000;
            default:                mult = 10'd1;
        endcase
        prod_full = {{gdd_pkg::MULT_W{1'b0}}, i_step_count} *
                    {{gdd_pkg::COUNT_W{1'b0}}, mult};
        n_prod    = WIDE_W'(prod_full);
    end

    // Year residue modulo 25, first fold. Since 2**10 is -1 modulo 25, the
    // 10-bit chunks of the year add and subtract alternately; a negative
    // year adds 25 minus the residue of 2**YEAR_BITS.
    always_comb begin
        year_ext = 32'(r_year);
        fold_sum = {2'b00, year_ext[9:0]} + {2'b00, year_ext[29:20]}
                 + (12'd1025 - {2'b00, year_ext[19:10]})
                 + (12'd25 - {10'd0, year_ext[31:30]});
        if (r_year[YEAR_BITS-1]) begin
            fold_sum = fold_sum + {7'd0, NEG_RES};
        end
    end

    // Second fold: one more 2**10 step, then two steps with 32 = 7 modulo 25,
    // and a final compare and subtract against 75, 50 and 25.
    always_comb begin
        fold_hi  = {1'b0, r_fold[9:0]} + 11'd25 - {9'd0, r_fold[11:10]};
        fold_mid = {fold_hi[10:5], 2'b00} + {1'b0, fold_hi[10:5], 1'b0}
                 + {2'b00, fold_hi[10:5]} + {3'b000, fold_hi[4:0]};
        fold_lo  = {2'b00, fold_mid[7:5], 2'b00} + {3'b000, fold_mid[7:5], 1'b0}
                 + {4'b0000, fold_mid[7:5]} + {2'b00, fold_mid[4:0]};
        if (fold_lo >= 7'd75) begin
            res_fold = RES_W'(fold_lo - 7'd75);
        end else if (fold_lo >= 7'd50) begin
            res_fold = RES_W'(fold_lo - 7'd50);
        end else if (fold_lo >= 7'd25) begin
            res_fold = RES_W'(fold_lo - 7'd25);
        end else begin
            res_fold = RES_W'(fold_lo);
        end
    end

    // Leap year: divisible by 4 and not by 100, or divisible by 400.
    assign leap = (r_year[1:0] == 2'b00) && ((r_res != '0) || (r_year[3:0] == 4'b0000));

    // One day or one month back.
    always_comb begin
        prev_month = (r_month == 4'd1) ? 4'd12 : (r_month - 4'd1);
        lim        = gdd_pkg::days_in(prev_month, leap);
        n_month    = r_month;
        n_day      = r_day;
        year_dec   = 1'b0;
        if (r_month_mode) begin
            n_month  = prev_month;
            year_dec = (r_month == 4'd1);
            n_day    = (r_day > lim) ? lim : r_day;
        end else if (r_day == 5'd1) begin
            n_month  = prev_month;
            year_dec = (r_month == 4'd1);
            n_day    = lim;
        end else begin
            n_day = r_day - 5'd1;
        end
    end

    // Residue after a year decrement, including the wrap to the top year.
    always_comb begin
        wrap_sum = {1'b0, r_res} + {1'b0, POW_RES};
        if (r_year == YEAR_MIN) begin
            if (wrap_sum == '0) begin
                res_dec = gdd_pkg::RES_MOD - 5'd1;
            end else if (wrap_sum > {1'b0, gdd_pkg::RES_MOD}) begin
                res_dec = RES_W'(wrap_sum - {1'b0, gdd_pkg::RES_MOD} - 6'd1);
            end else begin
                res_dec = RES_W'(wrap_sum - 6'd1);
            end
        end else begin
            res_dec = (r_res == '0) ? (gdd_pkg::RES_MOD - 5'd1) : (r_res - 5'd1);
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_day        <= fix_day;
            r_month      <= fix_month;
            r_year       <= i_start_year;
            r_steps      <= load_steps;
            r_prod       <= n_prod;
            r_mod_phase  <= 1'b0;
            r_res        <= '0;
            r_month_mode <= (gdd_pkg::t_cmd'(i_command) == gdd_pkg::CMD_MONTHS);
        end else if (i_cmd.mod_step) begin
            if (r_mod_phase) begin
                r_res <= res_fold;
            end else begin
                r_fold <= fold_sum;
            end
            r_mod_phase <= 1'b1;
        end else if (i_cmd.date_step) begin
            r_day   <= n_day;
            r_month <= n_month;
            r_steps <= r_steps - 1'b1;
            if (year_dec) begin
                r_year <= r_year - YEAR_ONE;
                r_res  <= res_dec;
            end
        end else if (i_cmd.year_sub) begin
            r_year <= r_year - r_prod[YEAR_BITS-1:0];
        end
    end

    assign o_status.mod_last   = r_mod_phase;
    assign o_status.steps_zero = (r_steps == '0);

    assign o_result_day   = r_day;
    assign o_result_month = r_month;
    assign o_result_year  = r_year;

endmodule
